@@ hdl/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TSP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the block clock and reset.
`define TSP_ASSERT(label, prop, msg) \
  `TSP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/tsp_pkg.sv @@
`timescale 1ns / 1ps

package tsp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FC_W      = 8;
  localparam int unsigned VAL_W     = 25;
  localparam int unsigned TIME_W    = 19;
  localparam int unsigned FLAG_W    = 5;
  localparam int unsigned OUT_PAD_W = 6;
  localparam int unsigned OUT_TDATA_W =
      BYTE_W + VAL_W + TIME_W + VAL_W + FLAG_W + OUT_PAD_W;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  localparam logic [BYTE_W-1:0] TEXT_LIMIT_RST = 8'd16;
  localparam logic [VAL_W-1:0]  MAG_CAP        = 25'h0FF_FFFF;
  localparam logic [VAL_W-1:0]  GROUP_CAP      = 25'd255;
  localparam logic [11:0]       SECS_PER_HOUR  = 12'(60 * 60);
  localparam logic [11:0]       SECS_PER_MIN   = 12'd60;
  localparam logic [11:0]       SECS_PER_SEC   = 12'd1;

  // Bit positions in valid_flags.
  localparam int unsigned FLAG_COMPLETE = 0;
  localparam int unsigned FLAG_TIME     = 1;
  localparam int unsigned FLAG_LAT      = 2;
  localparam int unsigned FLAG_LONG     = 3;
  localparam int unsigned FLAG_ALT      = 4;

  typedef enum logic [1:0] {
    KIND_CALL    = 2'd0,
    KIND_LAT     = 2'd1,
    KIND_LONG    = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [10:0] {
    PH_SEARCH    = 11'b000_0000_0001,
    PH_DOLLARS   = 11'b000_0000_0010,
    PH_CALL      = 11'b000_0000_0100,
    PH_SEQ       = 11'b000_0000_1000,
    PH_TIME      = 11'b000_0001_0000,
    PH_TIME_TAIL = 11'b000_0010_0000,
    PH_LAT       = 11'b000_0100_0000,
    PH_LONG      = 11'b000_1000_0000,
    PH_ALT       = 11'b001_0000_0000,
    PH_TAIL      = 11'b010_0000_0000,
    PH_ERROR     = 11'b100_0000_0000
  } phase_e;

  // Stage of the text-to-integer conversion.
  typedef enum logic [3:0] {
    NM_SKIP   = 4'b0001,
    NM_SIGN   = 4'b0010,
    NM_DIGITS = 4'b0100,
    NM_STOP   = 4'b1000
  } num_mode_e;

  typedef struct packed {
    num_mode_e         mode;
    logic              neg;
    logic [VAL_W-1:0]  acc;
  } num_st_t;

  typedef struct packed {
    kind_e              kind;
    logic [BYTE_W-1:0]  text_char;
    logic [VAL_W-1:0]   sequence_res;
    logic [TIME_W-1:0]  time_seconds;
    logic [VAL_W-1:0]   altitude;
    logic [FLAG_W-1:0]  valid_flags;
    logic               final_res;
  } res_t;

  typedef struct packed {
    logic char_vld;
    res_t char_res;
    logic sum_vld;
    res_t sum_res;
  } core_res_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [VAL_W-1:0] signed_of(input logic neg,
                                                 input logic [VAL_W-1:0] mag);
    return neg ? (VAL_W'(0) - mag) : mag;
  endfunction

  // One character into the text-to-integer conversion. The magnitude is
  // clamped at cap.
  function automatic num_st_t num_feed(input num_st_t s,
                                       input logic [BYTE_W-1:0] c,
                                       input logic [VAL_W-1:0] cap);
    num_st_t          r;
    logic             digit;
    logic [3:0]       d;
    logic [VAL_W+3:0] v;
    r     = s;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d     = c[3:0];
    v     = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + (VAL_W + 4)'(d);
    case (s.mode)
      NM_SKIP: begin
        if (is_space(c)) begin
          r = s;
        end else if (c == CH_PLUS) begin
          r.mode = NM_SIGN;
        end else if (c == CH_MINUS) begin
          r.neg  = 1'b1;
          r.mode = NM_SIGN;
        end else if (digit) begin
          r.acc  = VAL_W'(d);
          r.mode = NM_DIGITS;
        end else begin
          r.mode = NM_STOP;
        end
      end
      NM_SIGN: begin
        if (digit) begin
          r.acc  = VAL_W'(d);
          r.mode = NM_DIGITS;
        end else begin
          r.mode = NM_STOP;
        end
      end
      NM_DIGITS: begin
        if (digit) begin
          r.acc = (v > (VAL_W + 4)'(cap)) ? cap : v[VAL_W-1:0];
        end else begin
          r.mode = NM_STOP;
        end
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tsp_core.sv @@
`timescale 1ns / 1ps

module tsp_core import tsp_pkg::*; #(
  parameter int unsigned DIGIT_LIMIT = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              last_i,
  input  logic [BYTE_W-1:0] text_limit_i,
  output core_res_t         res_o
);

  localparam logic [FC_W-1:0] DIG_LIM     = FC_W'(DIGIT_LIMIT);
  localparam logic [FC_W-1:0] TIME_COLON1 = 8'd2;
  localparam logic [FC_W-1:0] TIME_COLON2 = 8'd5;
  localparam logic [FC_W-1:0] TIME_LEN    = 8'd8;

  phase_e            phase_q, phase_d;
  logic [FC_W-1:0]   fc_q, fc_d;
  num_mode_e         nmode_q, nmode_d;
  logic              neg_q, neg_d;
  logic [VAL_W-1:0]  seq_q, seq_d;
  logic [7:0]        grp_q, grp_d;
  logic [TIME_W-1:0] time_q, time_d;
  logic [VAL_W-1:0]  alt_q, alt_d;
  logic [4:1]        flags_q, flags_d;
  logic              ferr_q, ferr_d;

  logic              is_comma;
  logic              emit;
  kind_e             emit_kind;
  num_st_t           fed_seq, fed_alt, fed_grp, seed_grp;
  logic              grp_start;
  logic [7:0]        grp_val;
  logic [11:0]       weight;
  logic [19:0]       prod, tsum;
  logic [VAL_W-1:0]  seq_fin, alt_fin;
  logic              seq_open;
  logic [FLAG_W-1:0] sum_flags;

  assign is_comma = (byte_i == CH_COMMA);

  assign fed_seq = num_feed(num_st_t'{mode: nmode_q, neg: neg_q, acc: seq_q}, byte_i, MAG_CAP);
  assign fed_alt = num_feed(num_st_t'{mode: nmode_q, neg: neg_q, acc: alt_q}, byte_i, MAG_CAP);

  // Time groups: a new conversion starts on the first character of each pair.
  assign grp_start = (fc_q == 8'd0) || (fc_q == 8'd3) || (fc_q == 8'd6);
  assign seed_grp  = grp_start ? num_st_t'{mode: NM_SKIP, neg: 1'b0, acc: '0}
                               : num_st_t'{mode: nmode_q, neg: neg_q, acc: VAL_W'(grp_q)};
  assign fed_grp   = num_feed(seed_grp, byte_i, GROUP_CAP);
  assign grp_val   = fed_grp.neg ? 8'd0 : fed_grp.acc[7:0];

  always_comb begin
    case (fc_q)
      8'd1:    weight = SECS_PER_HOUR;
      8'd4:    weight = SECS_PER_MIN;
      default: weight = SECS_PER_SEC;
    endcase
  end

  assign prod = 20'(grp_val) * 20'(weight);
  assign tsum = 20'(time_q) + prod;

  always_comb begin
    phase_d   = phase_q;
    fc_d      = fc_q;
    nmode_d   = nmode_q;
    neg_d     = neg_q;
    seq_d     = seq_q;
    grp_d     = grp_q;
    time_d    = time_q;
    alt_d     = alt_q;
    flags_d   = flags_q;
    ferr_d    = ferr_q;
    emit      = 1'b0;
    emit_kind = KIND_CALL;
    case (phase_q)
      PH_SEARCH: begin
        if (byte_i == CH_DOLLAR) begin
          phase_d = PH_DOLLARS;
        end
      end
      PH_DOLLARS: begin
        if (byte_i != CH_DOLLAR) begin
          fc_d = '0;
          if (is_comma) begin
            phase_d = PH_SEQ;
            nmode_d = NM_SKIP;
            neg_d   = 1'b0;
            seq_d   = '0;
          end else begin
            phase_d = PH_CALL;
            if (text_limit_i != '0) begin
              fc_d = 8'd1;
              emit = 1'b1;
            end
          end
        end
      end
      PH_CALL: begin
        if (is_comma) begin
          phase_d = PH_SEQ;
          fc_d    = '0;
          nmode_d = NM_SKIP;
          neg_d   = 1'b0;
          seq_d   = '0;
        end else if (fc_q < text_limit_i) begin
          fc_d = fc_q + 8'd1;
          emit = 1'b1;
        end
      end
      PH_SEQ: begin
        if (is_comma) begin
          seq_d   = signed_of(neg_q, seq_q);
          phase_d = PH_TIME;
          fc_d    = '0;
          time_d  = '0;
        end else if (fc_q < DIG_LIM) begin
          fc_d    = fc_q + 8'd1;
          nmode_d = fed_seq.mode;
          neg_d   = fed_seq.neg;
          seq_d   = fed_seq.acc;
        end
      end
      PH_TIME: begin
        if ((fc_q == '0) && is_comma) begin
          phase_d = PH_LAT;
        end else if (is_comma ||
                     (((fc_q == TIME_COLON1) || (fc_q == TIME_COLON2)) &&
                      (byte_i != CH_COLON))) begin
          ferr_d  = 1'b1;
          phase_d = PH_ERROR;
        end else begin
          if ((fc_q != TIME_COLON1) && (fc_q != TIME_COLON2)) begin
            nmode_d = fed_grp.mode;
            neg_d   = fed_grp.neg;
            grp_d   = fed_grp.acc[7:0];
            if ((fc_q == 8'd1) || (fc_q == 8'd4) || (fc_q == 8'd7)) begin
              time_d = tsum[TIME_W-1:0];
            end
          end
          fc_d = fc_q + 8'd1;
          if ((fc_q + 8'd1) == TIME_LEN) begin
            flags_d[FLAG_TIME] = 1'b1;
            phase_d            = PH_TIME_TAIL;
          end
        end
      end
      PH_TIME_TAIL: begin
        if (is_comma) begin
          phase_d = PH_LAT;
          fc_d    = '0;
        end
      end
      PH_LAT: begin
        emit_kind = KIND_LAT;
        if (is_comma) begin
          phase_d = PH_LONG;
          fc_d    = '0;
        end else begin
          flags_d[FLAG_LAT] = 1'b1;
          if (fc_q < text_limit_i) begin
            fc_d = fc_q + 8'd1;
            emit = 1'b1;
          end
        end
      end
      PH_LONG: begin
        emit_kind = KIND_LONG;
        if (is_comma) begin
          phase_d = PH_ALT;
          fc_d    = '0;
          nmode_d = NM_SKIP;
          neg_d   = 1'b0;
          alt_d   = '0;
        end else begin
          flags_d[FLAG_LONG] = 1'b1;
          if (fc_q < text_limit_i) begin
            fc_d = fc_q + 8'd1;
            emit = 1'b1;
          end
        end
      end
      PH_ALT: begin
        if (is_comma) begin
          if (flags_q[FLAG_ALT]) begin
            alt_d = signed_of(neg_q, alt_q);
          end
          phase_d = PH_TAIL;
        end else begin
          flags_d[FLAG_ALT] = 1'b1;
          if (fc_q < DIG_LIM) begin
            fc_d    = fc_q + 8'd1;
            nmode_d = fed_alt.mode;
            neg_d   = fed_alt.neg;
            alt_d   = fed_alt.acc;
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Summary: an open number field is closed with what it holds so far.
  assign seq_fin  = (phase_d == PH_SEQ) ? signed_of(neg_d, seq_d) : seq_d;
  assign alt_fin  = ((phase_d == PH_ALT) && flags_d[FLAG_ALT]) ?
                    signed_of(neg_d, alt_d) : alt_d;
  assign seq_open = (phase_d == PH_SEQ) || (phase_d == PH_TIME) ||
                    (phase_d == PH_TIME_TAIL) || (phase_d == PH_LAT) ||
                    (phase_d == PH_LONG) || (phase_d == PH_ALT) ||
                    (phase_d == PH_TAIL);
  assign sum_flags = {flags_d, 1'b1};

  always_comb begin
    res_o.char_vld              = emit;
    res_o.char_res.kind         = emit_kind;
    res_o.char_res.text_char    = byte_i;
    res_o.char_res.sequence_res = '0;
    res_o.char_res.time_seconds = '0;
    res_o.char_res.altitude     = '0;
    res_o.char_res.valid_flags  = '0;
    res_o.char_res.final_res    = !last_i;

    res_o.sum_vld              = last_i;
    res_o.sum_res.kind         = KIND_SUMMARY;
    res_o.sum_res.text_char    = '0;
    res_o.sum_res.final_res    = 1'b1;
    if (ferr_d) begin
      res_o.sum_res.sequence_res = '0;
      res_o.sum_res.time_seconds = '0;
      res_o.sum_res.altitude     = '0;
      res_o.sum_res.valid_flags  = '0;
    end else begin
      res_o.sum_res.sequence_res = seq_open ? seq_fin : '0;
      res_o.sum_res.time_seconds = sum_flags[FLAG_TIME] ? time_d : '0;
      res_o.sum_res.altitude     = sum_flags[FLAG_ALT] ? alt_fin : '0;
      res_o.sum_res.valid_flags  = sum_flags;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      fc_q    <= '0;
      nmode_q <= NM_SKIP;
      neg_q   <= 1'b0;
      seq_q   <= '0;
      grp_q   <= '0;
      time_q  <= '0;
      alt_q   <= '0;
      flags_q <= '0;
      ferr_q  <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q <= PH_SEARCH;
        fc_q    <= '0;
        nmode_q <= NM_SKIP;
        neg_q   <= 1'b0;
        seq_q   <= '0;
        grp_q   <= '0;
        time_q  <= '0;
        alt_q   <= '0;
        flags_q <= '0;
        ferr_q  <= 1'b0;
      end else begin
        phase_q <= phase_d;
        fc_q    <= fc_d;
        nmode_q <= nmode_d;
        neg_q   <= neg_d;
        seq_q   <= seq_d;
        grp_q   <= grp_d;
        time_q  <= time_d;
        alt_q   <= alt_d;
        flags_q <= flags_d;
        ferr_q  <= ferr_d;
      end
    end
  end

endmodule

@@ hdl/tsp_out_stage.sv @@
`timescale 1ns / 1ps

module tsp_out_stage import tsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  core_res_t core_res_i,
  input  logic      ready_i,
  output logic      valid_o,
  output res_t      res_o,
  output logic      room_o
);

  logic out_vld_q, out_vld_d;
  res_t out_res_q, out_res_d;
  logic pend_vld_q, pend_vld_d;
  res_t pend_res_q, pend_res_d;
  logic slot_free;

  assign slot_free = !out_vld_q || ready_i;
  // The parser may only run when the result register frees up and no
  // summary is still parked behind a character.
  assign room_o    = slot_free && !pend_vld_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_res_d  = out_res_q;
    pend_vld_d = pend_vld_q;
    pend_res_d = pend_res_q;
    if (slot_free) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_res_d  = pend_res_q;
        pend_vld_d = 1'b0;
      end else if (take_i && (core_res_i.char_vld || core_res_i.sum_vld)) begin
        out_vld_d  = 1'b1;
        out_res_d  = core_res_i.char_vld ? core_res_i.char_res : core_res_i.sum_res;
        pend_vld_d = core_res_i.char_vld && core_res_i.sum_vld;
        pend_res_d = core_res_i.sum_res;
      end else begin
        out_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    pend_res_q <= pend_res_d;
  end

  assign valid_o = out_vld_q;
  assign res_o   = out_res_q;

endmodule

@@ hdl/telemetry_sentence_parser.sv @@
`timescale 1ns / 1ps

// Telemetry sentence parser. Sentence bytes enter on the slave stream, one
// byte per request, with tlast marking the final byte of a buffer. Everything
// up to and including the first run of '$' is skipped; the rest is read as
// comma-separated fields callsign, sequence, time, latitude, longitude and
// altitude. Each callsign, latitude and longitude character up to the limit
// held in the configuration register comes out as a character result; the
// final byte of a buffer adds a summary result carrying the sequence number,
// the time in seconds, the altitude and the validity flags, after which the
// parser starts over. The block takes one byte per clock cycle while the
// result side has room: a byte is registered, parsed by combinational logic
// whose longest path is the multiply-by-ten accumulate followed by the sign
// correction, and its result lands in the output register. A byte that
// yields both a character and a summary parks the summary in a holding slot,
// and the byte after it waits until that summary reaches the output register.
// The configuration register may only be written while no byte is in flight.
module telemetry_sentence_parser import tsp_pkg::*; #(
  parameter int unsigned DIGIT_LIMIT = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Sentence bytes.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] byte_in
  input  logic                   s_axis_tlast,   // end_of_buffer
  // Results.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] text_char, [32:8] sequence_res, [51:33] time_seconds,
  // [76:52] altitude, [81:77] valid_flags, [87:82] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]             m_axis_tuser,   // [1:0] kind
  output logic                   m_axis_tlast,   // final_res
  // Text limit register write.
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [BYTE_W-1:0]      cfg_data_i
);

  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_last_q;
  logic [BYTE_W-1:0] text_limit_q;
  logic              in_fire;
  logic              room;
  logic              take;
  core_res_t         core_res;
  res_t              out_res;

  // Configuration is accepted in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_limit_q <= TEXT_LIMIT_RST;
    end else if (cfg_valid_i) begin
      text_limit_q <= cfg_data_i;
    end
  end

  // Input register: the parser consumes it as soon as the result side has
  // room, and a new byte can be loaded in the same cycle.
  assign take          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || room;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (take) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Field parser: holds the sentence state and forms up to two results.
  tsp_core #(
    .DIGIT_LIMIT (DIGIT_LIMIT)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .byte_i       (in_byte_q),
    .last_i       (in_last_q),
    .text_limit_i (text_limit_q),
    .res_o        (core_res)
  );

  // Result register with a holding slot for a summary that follows a
  // character from the same byte.
  tsp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .core_res_i (core_res),
    .ready_i    (m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .res_o      (out_res),
    .room_o     (room)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_res.valid_flags, out_res.altitude,
                         out_res.time_seconds, out_res.sequence_res, out_res.text_char};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.final_res;

endmodule

@@ hdl/tsp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsp_checker import tsp_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]             m_axis_tuser,
  input logic                   m_axis_tlast
);

  // A result that waits must hold still.
  `TSP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // A summary always closes the results of its byte.
  `TSP_ASSERT(a_sum_last, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY) |-> m_axis_tlast, "summary without final mark")

  // Character results carry no numbers or flags.
  `TSP_ASSERT(a_char_clean, m_axis_tvalid && (m_axis_tuser != KIND_SUMMARY) |-> (m_axis_tdata[OUT_TDATA_W-1:BYTE_W] == '0), "character result with numeric payload")

  // A summary is either fully cleared by a time error or marked complete.
  `TSP_ASSERT(a_sum_flags, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY) |-> (m_axis_tdata[81:77] == 5'd0) || m_axis_tdata[77], "summary flags inconsistent")

endmodule

bind telemetry_sentence_parser tsp_checker u_tsp_checker (.*);

@@ tb/telemetry_sentence_parser_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the telemetry sentence parser. Sentence bytes are
// streamed into the slave port from a queue, and every accepted byte is run
// through a cycle-free parser model that predicts the character and summary
// records the block must produce. Records leaving the master port are checked
// field by field against the oldest prediction. The run goes through several
// text limits, including both extremes, and the receiver holds off once for a
// long stretch so that the block fills up and stalls its input.
module telemetry_sentence_parser_tb;
  import tsp_pkg::*;

  localparam int unsigned DIGITS_MAX      = 7;
  localparam int unsigned RESET_CYCLES    = 9;
  localparam int unsigned ITEMS_PER_PHASE = 275;
  localparam int unsigned PHASE_COUNT     = 6;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned VAL_MASK        = (1 << VAL_W) - 1;
  localparam int unsigned TIME_MASK       = (1 << TIME_W) - 1;

  // One sentence byte waiting for the slave port.
  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } byte_item_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [BYTE_W-1:0]      cfg_data_i    = '0;

  // Stimulus bookkeeping.
  byte_item_t        byte_q[$];
  logic [BYTE_W-1:0] draft[$];
  int unsigned       items_added   = 0;
  int unsigned       bytes_offered = 0;
  int unsigned       bytes_taken   = 0;
  int unsigned       idle_pct      = 33;
  logic              hold_go       = 1'b0;
  logic              hold_done     = 1'b0;
  int unsigned       hold_left     = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       mismatch_count = 0;

  // Records the parser is predicted to emit, oldest first.
  res_t parsed_q[$];

  // Parser model state. The declared values are the state after reset.
  logic [BYTE_W-1:0] text_lim  = TEXT_LIMIT_RST;
  phase_e            ph        = PH_SEARCH;
  int unsigned       fcount    = 0;
  num_mode_e         nmode     = NM_SKIP;
  logic              neg       = 1'b0;
  int unsigned       seq_mag   = 0;
  int unsigned       group_mag = 0;
  int unsigned       tsec      = 0;
  int unsigned       alt_mag   = 0;
  logic [FLAG_W-1:0] flags     = '0;
  logic              bad_time  = 1'b0;

  telemetry_sentence_parser #(
    .DIGIT_LIMIT(DIGITS_MAX)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------

  // A number field restarts its conversion with no sign seen.
  task automatic open_number();
    nmode = NM_SKIP;
    neg   = 1'b0;
  endtask

  // Two's complement of a magnitude at the 25-bit result width, using the
  // sign of the number being converted.
  function automatic int unsigned signed_code(input int unsigned mag);
    return neg ? ((32'd0 - mag) & VAL_MASK) : (mag & VAL_MASK);
  endfunction

  // One character into the text-to-integer conversion. Leading white space
  // is skipped, one sign is allowed, digits accumulate with saturation at
  // cap, and anything else stops the conversion for good.
  task automatic take_numeral(input logic [BYTE_W-1:0] c, inout int unsigned acc,
                              input int unsigned cap);
    logic        is_digit;
    logic        blank;
    int unsigned grown;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    blank    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    grown    = acc * 10 + (32'(c) - 32'(CH_ZERO));
    case (nmode)
      NM_SKIP: begin
        if (c == CH_PLUS) begin
          nmode = NM_SIGN;
        end else if (c == CH_MINUS) begin
          neg   = 1'b1;
          nmode = NM_SIGN;
        end else if (is_digit) begin
          acc   = 32'(c) - 32'(CH_ZERO);
          nmode = NM_DIGITS;
        end else if (!blank) begin
          nmode = NM_STOP;
        end
      end
      NM_SIGN: begin
        if (is_digit) begin
          acc   = 32'(c) - 32'(CH_ZERO);
          nmode = NM_DIGITS;
        end else begin
          nmode = NM_STOP;
        end
      end
      NM_DIGITS: begin
        if (is_digit) begin
          acc = (grown > cap) ? cap : grown;
        end else begin
          nmode = NM_STOP;
        end
      end
      default: begin
      end
    endcase
  endtask

  // A latitude or longitude character. Any non-comma marks the field as
  // present, but only the first text_lim characters are passed out.
  task automatic take_text(input logic [BYTE_W-1:0] c, input phase_e next_ph,
                           input int unsigned flag_pos, output logic shown);
    shown = 1'b0;
    if (c == CH_COMMA) begin
      ph     = next_ph;
      fcount = 0;
      if (next_ph == PH_ALT) begin
        open_number();
        alt_mag = 0;
      end
    end else begin
      flags[flag_pos] = 1'b1;
      if (fcount < text_lim) begin
        fcount++;
        shown = 1'b1;
      end
    end
  endtask

  // Advance the model by one accepted byte and queue the records it causes.
  task automatic parse_sentence_byte(input logic [BYTE_W-1:0] c, input logic last);
    res_t        rec;
    logic        emit;
    kind_e       knd;
    int unsigned weight;
    emit = 1'b0;
    knd  = KIND_CALL;
    case (ph)
      PH_SEARCH: begin
        if (c == CH_DOLLAR) ph = PH_DOLLARS;
      end
      PH_DOLLARS: begin
        // The first byte after the run of dollar signs opens the callsign.
        if (c != CH_DOLLAR) begin
          ph     = PH_CALL;
          fcount = 0;
          if (c == CH_COMMA) begin
            ph = PH_SEQ;
            open_number();
            seq_mag = 0;
          end else if (fcount < text_lim) begin
            fcount++;
            emit = 1'b1;
          end
        end
      end
      PH_CALL: begin
        if (c == CH_COMMA) begin
          ph     = PH_SEQ;
          fcount = 0;
          open_number();
          seq_mag = 0;
        end else if (fcount < text_lim) begin
          fcount++;
          emit = 1'b1;
        end
      end
      PH_SEQ: begin
        if (c == CH_COMMA) begin
          seq_mag = signed_code(seq_mag);
          ph      = PH_TIME;
          fcount  = 0;
          tsec    = 0;
        end else if (fcount < DIGITS_MAX) begin
          fcount++;
          take_numeral(c, seq_mag, 32'(MAG_CAP));
        end
      end
      PH_TIME: begin
        // Exactly hh:mm:ss. An empty field skips ahead, a misplaced colon or
        // an early comma poisons the rest of the buffer.
        if (fcount == 0 && c == CH_COMMA) begin
          ph = PH_LAT;
        end else if (c == CH_COMMA || ((fcount == 2 || fcount == 5) && c != CH_COLON)) begin
          bad_time = 1'b1;
          ph       = PH_ERROR;
        end else begin
          if (fcount != 2 && fcount != 5) begin
            if (fcount == 0 || fcount == 3 || fcount == 6) begin
              open_number();
              group_mag = 0;
            end
            take_numeral(c, group_mag, 32'(GROUP_CAP));
            if (fcount == 1 || fcount == 4 || fcount == 7) begin
              weight = (fcount == 1) ? 32'(SECS_PER_HOUR) :
                       (fcount == 4) ? 32'(SECS_PER_MIN) : 32'(SECS_PER_SEC);
              // A group that reads negative adds nothing.
              tsec = (tsec + (neg ? 0 : group_mag) * weight) & TIME_MASK;
            end
          end
          fcount++;
          if (fcount == 8) begin
            flags[FLAG_TIME] = 1'b1;
            ph = PH_TIME_TAIL;
          end
        end
      end
      PH_TIME_TAIL: begin
        if (c == CH_COMMA) begin
          ph     = PH_LAT;
          fcount = 0;
        end
      end
      PH_LAT: begin
        if (fcount == 0 && c == CH_COMMA && !flags[FLAG_LAT]) begin
          ph = PH_LONG;
        end else begin
          take_text(c, PH_LONG, FLAG_LAT, emit);
          knd = KIND_LAT;
        end
      end
      PH_LONG: begin
        if (fcount == 0 && c == CH_COMMA && !flags[FLAG_LONG]) begin
          ph = PH_ALT;
          open_number();
          alt_mag = 0;
        end else begin
          take_text(c, PH_ALT, FLAG_LONG, emit);
          knd = KIND_LONG;
        end
      end
      PH_ALT: begin
        if (c == CH_COMMA) begin
          if (flags[FLAG_ALT]) alt_mag = signed_code(alt_mag);
          ph = PH_TAIL;
        end else begin
          flags[FLAG_ALT] = 1'b1;
          if (fcount < DIGITS_MAX) begin
            fcount++;
            take_numeral(c, alt_mag, 32'(MAG_CAP));
          end
        end
      end
      default: begin
      end
    endcase

    if (emit) begin
      rec           = '0;
      rec.kind      = knd;
      rec.text_char = c;
      rec.final_res = !last;
      parsed_q.push_back(rec);
    end

    if (last) begin
      // The end mark closes whatever number is still open.
      if (ph == PH_SEQ) seq_mag = signed_code(seq_mag);
      if (ph == PH_ALT && flags[FLAG_ALT]) alt_mag = signed_code(alt_mag);
      rec           = '0;
      rec.kind      = KIND_SUMMARY;
      rec.final_res = 1'b1;
      if (!bad_time) begin
        rec.valid_flags = {flags[FLAG_W-1:1], 1'b1};
        if (ph == PH_SEQ || ph == PH_TIME || ph == PH_TIME_TAIL || ph == PH_LAT ||
            ph == PH_LONG || ph == PH_ALT || ph == PH_TAIL) begin
          rec.sequence_res = seq_mag[VAL_W-1:0];
        end
        if (flags[FLAG_TIME]) rec.time_seconds = tsec[TIME_W-1:0];
        if (flags[FLAG_ALT]) rec.altitude = alt_mag[VAL_W-1:0];
      end
      parsed_q.push_back(rec);
      // Back to the reset state; the text limit is kept.
      ph        = PH_SEARCH;
      fcount    = 0;
      nmode     = NM_SKIP;
      neg       = 1'b0;
      seq_mag   = 0;
      group_mag = 0;
      tsec      = 0;
      alt_mag   = 0;
      flags     = '0;
      bad_time  = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("Mismatch in %s at %0t ns: expected 0x%0h, got 0x%0h",
                 name, $time, want_v, got_v);
      end
    end
  endtask

  // Compare one record leaving the master port with the oldest prediction.
  // The tdata layout from bit 0 up is text_char, sequence_res, time_seconds,
  // altitude, valid_flags and six zero bits.
  task automatic check_record();
    res_t want;
    if (parsed_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("Unpredicted record at %0t ns: kind %0d, tdata 0x%0h",
                 $time, m_axis_tuser, m_axis_tdata);
      end
    end else begin
      want = parsed_q.pop_front();
      compare_field("kind", 32'(want.kind), 32'(m_axis_tuser));
      compare_field("text_char", 32'(want.text_char), 32'(m_axis_tdata[7:0]));
      compare_field("sequence_res", 32'(want.sequence_res), 32'(m_axis_tdata[32:8]));
      compare_field("time_seconds", 32'(want.time_seconds), 32'(m_axis_tdata[51:33]));
      compare_field("altitude", 32'(want.altitude), 32'(m_axis_tdata[76:52]));
      compare_field("valid_flags", 32'(want.valid_flags), 32'(m_axis_tdata[81:77]));
      compare_field("padding", 32'd0, 32'(m_axis_tdata[87:82]));
      compare_field("final_res", 32'(want.final_res), 32'(m_axis_tlast));
    end
  endtask

  // All handshakes are sampled at the rising edge, before the block updates
  // its registers. The configuration write is seen first so that a new text
  // limit applies to the bytes that follow it.
  always @(posedge clk_i) begin : watch_ports
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) text_lim = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        parse_sentence_byte(s_axis_tdata, s_axis_tlast);
        bytes_taken <= bytes_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) check_record();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      // A stuck handshake on any port ends the run.
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stream drivers
  // ---------------------------------------------------------------------

  // The sender holds a byte until it is taken, then either offers the next
  // queued byte or idles. A byte was taken when the monitor's count has
  // caught up with the number offered.
  always @(negedge clk_i) begin : drive_bytes
    byte_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || bytes_taken == bytes_offered) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        item           = byte_q.pop_front();
        s_axis_tdata  <= item.ch;
        s_axis_tlast  <= item.last;
        s_axis_tvalid <= 1'b1;
        bytes_offered <= bytes_offered + 1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, and once, when asked, holds off until its
  // hold counter runs out, which backs the block up into its input.
  always @(negedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic logic [BYTE_W-1:0] any_but_comma();
    logic [BYTE_W-1:0] b;
    b = 8'($urandom_range(255));
    return (b == CH_COMMA) ? CH_MINUS : b;
  endfunction

  // Free text without commas, mostly short and printable, now and then long
  // enough to run past a small text limit, sometimes empty.
  task automatic add_text(input int unsigned maxlen);
    int unsigned len;
    logic [BYTE_W-1:0] b;
    len = ($urandom_range(4) == 0) ? $urandom_range(maxlen) : $urandom_range(1, 6);
    repeat (len) begin
      b = 8'($urandom_range(33, 126));
      if (b == CH_COMMA) b = CH_PLUS;
      draft.push_back($urandom_range(1) ? b : any_but_comma());
    end
  endtask

  // A number field: optional white space and sign, up to ten digits so that
  // some run past the digit limit, and now and then a stray character.
  task automatic add_number();
    int unsigned r;
    if ($urandom_range(9) == 0) draft.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    r = $urandom_range(9);
    if (r < 3) draft.push_back(CH_MINUS);
    else if (r == 3) draft.push_back(CH_PLUS);
    repeat (($urandom_range(9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 7)) begin
      draft.push_back(CH_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(9) == 0) draft.push_back(any_but_comma());
  endtask

  // One two-character time group, usually two digits, sometimes signed,
  // padded or malformed.
  task automatic add_group();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: draft.push_back(CH_MINUS);
      1: draft.push_back(CH_SPACE);
      2: draft.push_back(CH_PLUS);
      3: draft.push_back(8'($urandom_range(65, 90)));
      default: draft.push_back(CH_ZERO + 8'($urandom_range(9)));
    endcase
    draft.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Move the draft sentence into the send queue, the end mark on its last byte.
  task automatic queue_draft();
    byte_item_t it;
    for (int i = 0; i < draft.size(); i++) begin
      it.ch   = draft[i];
      it.last = (i == draft.size() - 1);
      byte_q.push_back(it);
      items_added++;
    end
    draft.delete();
  endtask

  initial begin : stimulus
    string             opener;
    byte_item_t        lone;
    logic [BYTE_W-1:0] lim;
    int unsigned       target;
    int unsigned       cut;
    int unsigned       tstart;
    int unsigned       idx;
    int unsigned       r;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opener. A lone end mark of value FF before any dollar sign gives a
    // bare summary. The sentence after it opens with a zero byte and has a minus
    // sign in the sequence, a negative time group, text after the eighth time
    // character, an empty latitude and an altitude still open at the end.
    lone.ch   = 8'hFF;
    lone.last = 1'b1;
    byte_q.push_back(lone);
    items_added++;
    opener = "$$C,-9,01:-2:030,,x,5";
    draft.push_back(8'h00);
    for (int i = 0; i < opener.len(); i++) draft.push_back(opener[i]);
    queue_draft();

    for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
      // The text limit changes only while the parser is drained. The first
      // phase runs on the reset value.
      if (phase_no != 0) begin
        case (phase_no)
          1: lim = 8'd0;
          2: lim = 8'd255;
          3: lim = 8'($urandom_range(1, 254));
          4: lim = 8'd1;
          default: lim = TEXT_LIMIT_RST;
        endcase
        @(negedge clk_i);
        cfg_data_i  <= lim;
        cfg_valid_i <= 1'b1;
        do @(posedge clk_i); while (!cfg_ready_o);
        @(negedge clk_i);
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      // One phase runs without any idling on either side.
      idle_pct <= (phase_no == 3) ? 0 : 33;

      target = (phase_no + 1) * ITEMS_PER_PHASE;
      while (items_added < target) begin
        if ($urandom_range(99) < 8) begin
          // Line noise: raw bytes of any value.
          repeat ($urandom_range(1, 12)) draft.push_back(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(2)) draft.push_back(any_but_comma());
          repeat ($urandom_range(1, 3)) draft.push_back(CH_DOLLAR);
          add_text(20);
          draft.push_back(CH_COMMA);
          add_number();
          draft.push_back(CH_COMMA);

          // Time field: mostly well formed, else empty, with trailing text,
          // with a bad separator, or cut short by the next comma.
          tstart = draft.size();
          r = $urandom_range(99);
          if (r >= 10) begin
            add_group();
            draft.push_back(CH_COLON);
            add_group();
            draft.push_back(CH_COLON);
            add_group();
            if (r < 25) begin
              repeat ($urandom_range(1, 3)) draft.push_back(any_but_comma());
            end else if (r < 32) begin
              idx = tstart + ($urandom_range(1) ? 2 : 5);
              draft[idx] = any_but_comma();
              if (draft[idx] == CH_COLON) draft[idx] = CH_SPACE;
            end else if (r < 38) begin
              cut = tstart + $urandom_range(1, 7);
              while (draft.size() > cut) void'(draft.pop_back());
            end
          end
          draft.push_back(CH_COMMA);

          add_text(12);
          draft.push_back(CH_COMMA);
          add_text(12);
          draft.push_back(CH_COMMA);
          if ($urandom_range(9) != 0) add_number();
          if ($urandom_range(3) == 0) begin
            draft.push_back(CH_COMMA);
            add_text(6);
          end
          if ($urandom_range(1)) begin
            repeat (3) draft.push_back(any_but_comma());
            draft.push_back(8'h0A);
          end
          // Some buffers end in the middle of a field.
          if ($urandom_range(99) < 15) begin
            cut = $urandom_range(1, draft.size());
            while (draft.size() > cut) void'(draft.pop_back());
          end
        end
        queue_draft();
      end

      // Long receiver stall while the sender keeps pushing bytes.
      if (phase_no == 2) hold_go <= 1'b1;

      // Drain: every queued byte taken and every predicted record seen, then
      // a wait so that bytes that produce no record clear the pipeline.
      while (byte_q.size() != 0 || bytes_taken != items_added || parsed_q.size() != 0) begin
        @(negedge clk_i);
      end
      repeat (DRAIN_CYCLES) @(negedge clk_i);
    end

    if (mismatch_count == 0 && parsed_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
